/* hdl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BPSP_ASSERT_IMP(lbl, clk_e, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk_e) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("bpsp assertion failed");

// Next-cycle implication, disabled during reset.
`define BPSP_ASSERT_NXT(lbl, clk_e, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk_e) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("bpsp assertion failed");

`endif

/* hdl/bpsp_pkg.sv */
// Types, constants and control structs of the partition swap planner.
package bpsp_pkg;

	localparam int ID_W   = 6;
	localparam int IDX_W  = 11;
	localparam int CFG_W  = 7;
	localparam int KIND_W = 2;
	localparam int OUT_W  = 2;

	localparam int MAX_PARTITIONS_DEF = 64;
	localparam int MAX_ACCESSES_DEF   = 1024;

	localparam logic [CFG_W-1:0] CAP_RESET    = 7'd2;
	localparam logic [CFG_W-1:0] PCOUNT_RESET = 7'd64;

	typedef enum logic [KIND_W-1:0] {
		KIND_CLEAR    = 2'd0,
		KIND_APPEND   = 2'd1,
		KIND_SIMULATE = 2'd2
	} kind_t;

	typedef enum logic [OUT_W-1:0] {
		OUT_HIT   = 2'd0,
		OUT_ADMIT = 2'd1,
		OUT_EVICT = 2'd2,
		OUT_END   = 2'd3
	} outcome_t;

	typedef enum logic [0:0] {
		REG_CAPACITY = 1'b0,
		REG_PCOUNT   = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CUR,
		ST_DECIDE,
		ST_PART,
		ST_SCAN,
		ST_SWEEP,
		ST_EVICT,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic clear;
		logic append;
		logic set_end;
		logic rd_cur;
		logic take_cur;
		logic set_hit;
		logic admit;
		logic rd_partner;
		logic take_partner;
		logic start_scan;
		logic scan;
		logic sweep;
		logic evict;
		logic publish;
	} dp_cmd_t;

	typedef struct packed {
		logic past_end;
		logic hit;
		logic full;
		logic pos_odd;
		logic scan_done;
		logic sweep_last;
		logic out_free;
	} dp_status_t;

endpackage

/* hdl/belady_partition_swap_planner.sv */
// Top level of the partition swap planner: controller, datapath and sequence RAM.
//
// Clear and append requests complete in the idle state. A simulate request that
// hits, or that admits into a free slot, passes through the read, decide and
// finish states; a request past the end of the sequence goes straight to finish.
// A miss on a full buffer passes through the scan, sweep and evict states, with a
// partner state before the scan at an odd position where the pair partner is
// fetched first: the remaining sequence is read from the single read port of the
// sequence RAM one access per cycle to find each candidate's next use, then the
// partition ids are swept one per cycle to pick the victim. Results leave through
// an output register; the block accepts no request while a simulate step is in
// progress.
module belady_partition_swap_planner import bpsp_pkg::*; #(
	parameter int MAX_PARTITIONS = MAX_PARTITIONS_DEF,
	parameter int MAX_ACCESSES   = MAX_ACCESSES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [KIND_W-1:0] kind,
	input  logic [ID_W-1:0]   part_id,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [OUT_W-1:0]  outcome,
	output logic [ID_W-1:0]   admitted_partition,
	output logic [ID_W-1:0]   evicted_partition,
	output logic [IDX_W-1:0]  access_index
);

	dp_cmd_t    cmd;
	dp_status_t status;

	bpsp_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.kind    (kind),
		.in_stall(in_stall),
		.status  (status),
		.cmd     (cmd)
	);

	bpsp_dpath #(
		.MAX_PARTITIONS(MAX_PARTITIONS),
		.MAX_ACCESSES  (MAX_ACCESSES)
	) u_dpath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.part_id           (part_id),
		.out_stall         (out_stall),
		.out_valid         (out_valid),
		.outcome           (outcome),
		.admitted_partition(admitted_partition),
		.evicted_partition (evicted_partition),
		.access_index      (access_index),
		.cmd               (cmd),
		.status            (status)
	);

endmodule

/* hdl/bpsp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module bpsp_ram #(
	parameter int WIDTH = 6,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* hdl/bpsp_ctrl.sv */
// Sequencer that steps the datapath through clear, append and simulate requests.
module bpsp_ctrl import bpsp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [KIND_W-1:0] kind,
	output logic              in_stall,
	input  dp_status_t        status,
	output dp_cmd_t           cmd
);

	state_t state_q;
	state_t state_nxt;
	logic   accept;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && kind == KIND_SIMULATE) begin
					state_nxt = status.past_end ? ST_FINISH : ST_CUR;
				end
			end
			ST_CUR: state_nxt = ST_DECIDE;
			ST_DECIDE: begin
				if (status.hit || !status.full) begin
					state_nxt = ST_FINISH;
				end else if (status.pos_odd) begin
					state_nxt = ST_PART;
				end else begin
					state_nxt = ST_SCAN;
				end
			end
			ST_PART: state_nxt = ST_SCAN;
			ST_SCAN: begin
				if (status.scan_done) begin
					state_nxt = ST_SWEEP;
				end
			end
			ST_SWEEP: begin
				if (status.sweep_last) begin
					state_nxt = ST_EVICT;
				end
			end
			ST_EVICT: state_nxt = ST_FINISH;
			ST_FINISH: begin
				if (status.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.clear   = (kind == KIND_CLEAR);
					cmd.append  = (kind == KIND_APPEND);
					cmd.set_end = (kind == KIND_SIMULATE) && status.past_end;
					cmd.rd_cur  = (kind == KIND_SIMULATE) && !status.past_end;
				end
			end
			ST_CUR: cmd.take_cur = 1'b1;
			ST_DECIDE: begin
				if (status.hit) begin
					cmd.set_hit = 1'b1;
				end else if (!status.full) begin
					cmd.admit = 1'b1;
				end else if (status.pos_odd) begin
					cmd.rd_partner = 1'b1;
				end else begin
					cmd.start_scan = 1'b1;
				end
			end
			ST_PART: begin
				cmd.take_partner = 1'b1;
				cmd.start_scan   = 1'b1;
			end
			ST_SCAN:   cmd.scan    = 1'b1;
			ST_SWEEP:  cmd.sweep   = 1'b1;
			ST_EVICT:  cmd.evict   = 1'b1;
			ST_FINISH: cmd.publish = status.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

/* hdl/bpsp_dpath.sv */
// Datapath: sequence store, buffer state, next-use scan and victim selection.
module bpsp_dpath import bpsp_pkg::*; #(
	parameter int MAX_PARTITIONS = MAX_PARTITIONS_DEF,
	parameter int MAX_ACCESSES   = MAX_ACCESSES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic [ID_W-1:0]  part_id,
	input  logic             out_stall,
	output logic             out_valid,
	output logic [OUT_W-1:0] outcome,
	output logic [ID_W-1:0]  admitted_partition,
	output logic [ID_W-1:0]  evicted_partition,
	output logic [IDX_W-1:0] access_index,
	input  dp_cmd_t          cmd,
	output dp_status_t       status
);

	localparam int PW = $clog2(MAX_PARTITIONS);
	localparam int CW = $clog2(MAX_PARTITIONS + 1);
	localparam int LW = $clog2(MAX_ACCESSES + 1);
	localparam int AW = $clog2(MAX_ACCESSES);

	logic [CFG_W-1:0]          cap_q;
	logic [CFG_W-1:0]          pcount_q;
	logic [LW-1:0]             seq_len_q;
	logic [LW-1:0]             pos_q;
	logic [MAX_PARTITIONS-1:0] resident_q;
	logic [CW-1:0]             res_count_q;
	logic [ID_W-1:0]           cur_q;
	logic [ID_W-1:0]           partner_q;
	logic                      partner_vld_q;
	logic [LW-1:0]             scan_q;
	logic                      scan_vld_s1;
	logic [MAX_PARTITIONS-1:0] seen_q;
	logic                      seen_any_q;
	logic [PW-1:0]             last_new_q;
	logic [PW-1:0]             sweep_k_q;
	logic                      unseen_found_q;
	logic [PW-1:0]             unseen_id_q;
	outcome_t                  outcome_q;
	logic [ID_W-1:0]           victim_q;

	logic                      out_valid_q;
	outcome_t                  out_outcome_q;
	logic [ID_W-1:0]           out_admit_q;
	logic [ID_W-1:0]           out_evict_q;
	logic [IDX_W-1:0]          out_index_q;

	logic                      ram_we;
	logic [AW-1:0]             ram_raddr;
	logic [ID_W-1:0]           rd_data;
	logic [MAX_PARTITIONS-1:0] cand;
	logic                      cur_in;
	logic [PW-1:0]             cur_idx;
	logic                      rd_in;
	logic [PW-1:0]             rd_idx;
	logic                      scan_less;
	logic                      victim_found;
	logic [PW-1:0]             victim_idx;

	assign ram_we = cmd.append && (seq_len_q < LW'(MAX_ACCESSES));

	always_comb begin
		if (cmd.rd_cur || cmd.start_scan) begin
			ram_raddr = AW'(pos_q);
		end else if (cmd.rd_partner) begin
			ram_raddr = AW'(pos_q - LW'(1));
		end else begin
			ram_raddr = AW'(scan_q);
		end
	end

	bpsp_ram #(
		.WIDTH(ID_W),
		.DEPTH(MAX_ACCESSES)
	) u_seq_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(AW'(seq_len_q)),
		.wdata(part_id),
		.raddr(ram_raddr),
		.rdata(rd_data)
	);

	assign cur_in    = int'(cur_q) < MAX_PARTITIONS;
	assign cur_idx   = PW'(cur_q);
	assign rd_in     = int'(rd_data) < MAX_PARTITIONS;
	assign rd_idx    = PW'(rd_data);
	assign scan_less = scan_q < seq_len_q;

	// Candidates: resident, below the configured count, not the pair partner.
	always_comb begin
		for (int k = 0; k < MAX_PARTITIONS; k++) begin
			cand[k] = resident_q[k] && (k < int'(pcount_q)) &&
				!(partner_vld_q && (int'(partner_q) == k));
		end
	end

	// Never-used-again candidates beat any seen one; among seen ones the last first use wins.
	assign victim_found = unseen_found_q || seen_any_q;
	assign victim_idx   = unseen_found_q ? unseen_id_q : last_new_q;

	assign status.past_end   = pos_q >= seq_len_q;
	assign status.hit        = cur_in && resident_q[cur_idx];
	assign status.full       = int'(res_count_q) == int'(cap_q);
	assign status.pos_odd    = pos_q[0];
	assign status.scan_done  = !scan_vld_s1 && !scan_less;
	assign status.sweep_last = sweep_k_q == PW'(MAX_PARTITIONS - 1);
	assign status.out_free   = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= CAP_RESET;
			pcount_q    <= PCOUNT_RESET;
			seq_len_q   <= '0;
			pos_q       <= '0;
			resident_q  <= '0;
			res_count_q <= '0;
			scan_vld_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_CAPACITY: cap_q    <= cfg_data;
					REG_PCOUNT:   pcount_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.clear) begin
				seq_len_q   <= '0;
				pos_q       <= '0;
				resident_q  <= '0;
				res_count_q <= '0;
			end
			if (ram_we) begin
				seq_len_q <= seq_len_q + LW'(1);
			end
			if (cmd.admit && cur_in) begin
				resident_q[cur_idx] <= 1'b1;
				res_count_q         <= res_count_q + CW'(1);
			end
			if (cmd.evict) begin
				// drop the victim and take in the current partition in one update
				resident_q  <= (resident_q & ~(MAX_PARTITIONS'(victim_found) << victim_idx)) |
					(MAX_PARTITIONS'(cur_in) << cur_idx);
				res_count_q <= res_count_q - CW'(victim_found) + CW'(cur_in);
			end
			if (cmd.start_scan) begin
				scan_vld_s1 <= 1'b1;
			end else if (cmd.scan) begin
				scan_vld_s1 <= scan_less;
			end
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
				if (outcome_q != OUT_END) begin
					pos_q <= pos_q + LW'(1);
				end
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_cur) begin
			cur_q <= rd_data;
		end
		if (cmd.take_partner) begin
			partner_q <= rd_data;
		end
		if (cmd.set_end) begin
			outcome_q <= OUT_END;
			victim_q  <= '0;
		end
		if (cmd.set_hit) begin
			outcome_q <= OUT_HIT;
			victim_q  <= '0;
		end
		if (cmd.admit) begin
			outcome_q <= OUT_ADMIT;
			victim_q  <= '0;
		end
		if (cmd.start_scan) begin
			partner_vld_q  <= cmd.take_partner;
			scan_q         <= pos_q + LW'(1);
			seen_q         <= '0;
			seen_any_q     <= 1'b0;
			sweep_k_q      <= '0;
			unseen_found_q <= 1'b0;
		end
		if (cmd.scan) begin
			if (scan_less) begin
				scan_q <= scan_q + LW'(1);
			end
			// Record the first use of each candidate in scan order.
			if (scan_vld_s1 && rd_in && cand[rd_idx] && !seen_q[rd_idx]) begin
				seen_q[rd_idx] <= 1'b1;
				seen_any_q     <= 1'b1;
				last_new_q     <= rd_idx;
			end
		end
		if (cmd.sweep) begin
			sweep_k_q <= sweep_k_q + PW'(1);
			if (cand[sweep_k_q] && !seen_q[sweep_k_q]) begin
				unseen_found_q <= 1'b1;
				unseen_id_q    <= sweep_k_q;
			end
		end
		if (cmd.evict) begin
			outcome_q <= victim_found ? OUT_EVICT : OUT_ADMIT;
			victim_q  <= victim_found ? ID_W'(victim_idx) : '0;
		end
		if (cmd.publish) begin
			out_outcome_q <= outcome_q;
			out_admit_q   <= (outcome_q == OUT_END) ? '0 : cur_q;
			out_evict_q   <= victim_q;
			out_index_q   <= (outcome_q == OUT_END) ? IDX_W'(seq_len_q) : IDX_W'(pos_q);
		end
	end

	assign out_valid          = out_valid_q;
	assign outcome            = out_outcome_q;
	assign admitted_partition = out_admit_q;
	assign evicted_partition  = out_evict_q;
	assign access_index       = out_index_q;

endmodule

/* hdl/bpsp_checker.sv */
// Port-level checks of the partition swap planner, bound to the top level.
`include "assert_macros.svh"

module bpsp_checker import bpsp_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic [KIND_W-1:0] kind,
	input logic              out_valid,
	input logic              out_stall,
	input logic [OUT_W-1:0]  outcome,
	input logic [ID_W-1:0]   admitted_partition,
	input logic [ID_W-1:0]   evicted_partition
);

	logic                         sim_acc;
	logic                         end_out;
	logic                         plain_out;
	logic                         out_wait;
	logic [OUT_W+2*ID_W-1:0]      out_word;

	assign sim_acc   = in_valid && !in_stall && kind == KIND_SIMULATE;
	assign end_out   = out_valid && outcome == OUT_END;
	assign plain_out = out_valid && outcome != OUT_EVICT;
	assign out_wait  = out_valid && out_stall;
	assign out_word  = {outcome, admitted_partition, evicted_partition};

	// A simulate request keeps the input side busy in the following cycle.
	`BPSP_ASSERT_NXT(a_sim_busy, clk, arst_n, sim_acc, in_stall)

	// End of sequence carries no partitions.
	`BPSP_ASSERT_IMP(a_end_empty, clk, arst_n, end_out, {admitted_partition, evicted_partition} == '0)

	// Only an eviction names a victim.
	`BPSP_ASSERT_IMP(a_victim_only_evict, clk, arst_n, plain_out, evicted_partition == '0)

	// A stalled result holds.
	`BPSP_ASSERT_NXT(a_out_hold, clk, arst_n, out_wait, out_valid && $stable(out_word))

endmodule

bind belady_partition_swap_planner bpsp_checker u_bpsp_checker (.*);

/* dv/tb_belady_partition_swap_planner.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the partition swap planner: directed table, random plans, replay.
module tb_belady_partition_swap_planner;
	import bpsp_pkg::*;

	localparam int SEQ_DEPTH     = MAX_ACCESSES_DEF;
	localparam int NUM_PART      = MAX_PARTITIONS_DEF;
	localparam int RAND_ITEMS    = 400;
	localparam int LONG_LEN      = 64;
	localparam int LONG_SIMS     = 12;
	localparam int SETTLE_CYCLES = 8;
	localparam int TAIL_CYCLES   = 1200;
	localparam int HOLD_CYCLES   = 150;
	localparam int CYCLE_LIMIT   = 5_000_000;
	localparam int REPORT_MAX    = 10;

	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

	typedef struct packed {
		outcome_t         outcome;
		logic [ID_W-1:0]  admitted;
		logic [ID_W-1:0]  evicted;
		logic [IDX_W-1:0] index;
	} swap_result_t;

	typedef struct {
		bit                is_reg;
		cfg_reg_t          reg_sel;
		logic [CFG_W-1:0]  reg_val;
		logic [KIND_W-1:0] kind;
		logic [ID_W-1:0]   pid;
		bit                typed;
		swap_result_t      want;
	} plan_row_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic              cfg_index;
	logic [CFG_W-1:0]  cfg_data;
	logic              in_valid;
	logic              in_stall;
	logic [KIND_W-1:0] kind;
	logic [ID_W-1:0]   part_id;
	logic              out_valid;
	logic              out_stall;
	logic [OUT_W-1:0]  outcome;
	logic [ID_W-1:0]   admitted_partition;
	logic [ID_W-1:0]   evicted_partition;
	logic [IDX_W-1:0]  access_index;

	// replay state of the planner
	logic [ID_W-1:0]   seq_mem [0:SEQ_DEPTH-1];
	int unsigned       seq_len = 0;
	int unsigned       step_pos = 0;
	logic [NUM_PART-1:0] resident = '0;
	int unsigned       res_cnt = 0;
	int unsigned       cap_val = CAP_RESET;
	int unsigned       pcount_val = PCOUNT_RESET;

	swap_result_t      swap_q [$];
	plan_row_t         dir_rows [$];

	int                mismatches = 0;
	int                useful_reqs = 0;
	int                reg_writes = 0;
	int                results_seen = 0;
	int                outcome_tally [4] = '{0, 0, 0, 0};
	int                hold_req = 0;
	int                holds_done = 0;
	int                cycle_cnt = 0;
	bit                fast_mode = 1'b0;

	belady_partition_swap_planner u_dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_we),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.kind               (kind),
		.part_id            (part_id),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.outcome            (outcome),
		.admitted_partition (admitted_partition),
		.evicted_partition  (evicted_partition),
		.access_index       (access_index)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, swap_q.size());
			$display("[belady_partition_swap_planner] ERROR");
			$finish;
		end
	end

	function automatic int unsigned next_use(int unsigned pos, logic [ID_W-1:0] id);
		for (int unsigned j = pos; j < seq_len; j++)
			if (seq_mem[j] == id)
				return j - pos;
		return seq_len - pos;
	endfunction

	// Advance the replay state by one request; made is set when a result is due.
	task automatic plan_step(input logic [KIND_W-1:0] k, input logic [ID_W-1:0] pid,
			output bit made, output swap_result_t res);
		int unsigned     pos;
		int unsigned     best;
		int unsigned     victim;
		int unsigned     lim;
		int unsigned     d;
		logic [ID_W-1:0] cur;
		logic [ID_W-1:0] partner;
		bit              has_partner;
		bit              found;
		made = 1'b0;
		res = '0;
		case (k)
			KIND_CLEAR: begin
				seq_len = 0;
				step_pos = 0;
				resident = '0;
				res_cnt = 0;
			end
			KIND_APPEND: begin
				if (seq_len < SEQ_DEPTH) begin
					seq_mem[seq_len] = pid;
					seq_len++;
				end
			end
			KIND_SIMULATE: begin
				made = 1'b1;
				pos = step_pos;
				if (pos >= seq_len) begin
					res.outcome = OUT_END;
					res.index = IDX_W'(seq_len);
				end else begin
					cur = seq_mem[pos];
					victim = 0;
					res.outcome = OUT_ADMIT;
					if (resident[cur]) begin
						res.outcome = OUT_HIT;
					end else begin
						if (res_cnt == cap_val) begin
							found = 1'b0;
							best = 0;
							// the batch source stays put while its destination loads
							has_partner = pos[0];
							partner = has_partner ? seq_mem[pos-1] : '0;
							lim = pcount_val < NUM_PART ? pcount_val : NUM_PART;
							for (int unsigned kk = 0; kk < lim; kk++) begin
								if (!resident[kk] || (has_partner && ID_W'(kk) == partner))
									continue;
								d = next_use(pos, ID_W'(kk));
								if (d >= best) begin
									best = d;
									victim = kk;
									found = 1'b1;
								end
							end
							if (found) begin
								resident[victim] = 1'b0;
								res_cnt--;
								res.outcome = OUT_EVICT;
							end else begin
								victim = 0;
							end
						end
						resident[cur] = 1'b1;
						res_cnt++;
					end
					step_pos = pos + 1;
					res.admitted = cur;
					res.evicted = ID_W'(victim);
					res.index = IDX_W'(pos);
				end
			end
			default: ;
		endcase
	endtask

	task automatic flag_mismatch(input string msg);
		mismatches++;
		if (mismatches <= REPORT_MAX)
			$display("mismatch at cycle %0d: %s", cycle_cnt, msg);
	endtask

	task automatic check_result();
		swap_result_t want;
		if (swap_q.size() == 0) begin
			flag_mismatch($sformatf("unexpected result outcome=%0d adm=%0d ev=%0d idx=%0d",
				outcome, admitted_partition, evicted_partition, access_index));
			return;
		end
		want = swap_q.pop_front();
		results_seen++;
		outcome_tally[want.outcome]++;
		if (outcome !== want.outcome || admitted_partition !== want.admitted ||
				evicted_partition !== want.evicted || access_index !== want.index)
			flag_mismatch($sformatf(
				"exp outcome=%0d adm=%0d ev=%0d idx=%0d, got outcome=%0d adm=%0d ev=%0d idx=%0d",
				want.outcome, want.admitted, want.evicted, want.index,
				outcome, admitted_partition, evicted_partition, access_index));
	endtask

	// result side: check at the falling edge, stall at random or for a long hold-off
	initial begin
		int  w;
		bit  fire;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			fire = arst_n && out_valid && !out_stall;
			if (fire)
				check_result();
			@(posedge clk);
			if (hold_req > 0) begin
				w = hold_req;
				hold_req = 0;
				holds_done++;
				out_stall <= 1'b1;
				repeat (w) @(posedge clk);
				out_stall <= 1'b0;
			end else if (fire && !fast_mode) begin
				w = $urandom_range(0, 4);
				if (w > 0) begin
					out_stall <= 1'b1;
					repeat (w) @(posedge clk);
					out_stall <= 1'b0;
				end
			end
		end
	end

	task automatic send_req(input logic [KIND_W-1:0] k, input logic [ID_W-1:0] pid,
			input bit typed = 1'b0, input swap_result_t want = '0);
		int           gap;
		bit           made;
		swap_result_t res;
		gap = fast_mode ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		part_id <= pid;
		forever begin
			@(negedge clk);
			if (!in_stall)
				break;
			@(posedge clk);
		end
		if (k != KIND_UNUSED && !(k == KIND_APPEND && seq_len >= SEQ_DEPTH))
			useful_reqs++;
		plan_step(k, pid, made, res);
		if (made)
			swap_q.insert(swap_q.size(), typed ? want : res);
		@(posedge clk);
	endtask

	// Hold off until every result is back and any trailing request has retired.
	task automatic drain_plans();
		in_valid <= 1'b0;
		while (swap_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t sel, input logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= sel;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (sel == REG_CAPACITY)
			cap_val = val;
		else
			pcount_val = val;
		reg_writes++;
		@(posedge clk);
	endtask

	function automatic plan_row_t item_row(logic [KIND_W-1:0] k, logic [ID_W-1:0] p);
		plan_row_t row;
		row.is_reg = 1'b0;
		row.reg_sel = REG_CAPACITY;
		row.reg_val = '0;
		row.kind = k;
		row.pid = p;
		row.typed = 1'b0;
		row.want = '0;
		return row;
	endfunction

	function automatic plan_row_t check_row(logic [KIND_W-1:0] k, logic [ID_W-1:0] p,
			outcome_t o, int adm, int ev, int idx);
		plan_row_t row;
		row = item_row(k, p);
		row.typed = 1'b1;
		row.want.outcome = o;
		row.want.admitted = ID_W'(adm);
		row.want.evicted = ID_W'(ev);
		row.want.index = IDX_W'(idx);
		return row;
	endfunction

	function automatic plan_row_t reg_row(cfg_reg_t sel, logic [CFG_W-1:0] val);
		plan_row_t row;
		row = item_row(KIND_CLEAR, '0);
		row.is_reg = 1'b1;
		row.reg_sel = sel;
		row.reg_val = val;
		return row;
	endfunction

	function automatic void add_row(plan_row_t row);
		dir_rows.insert(dir_rows.size(), row);
	endfunction

	initial begin
		int              phase;
		int              plen;
		int              pool_n;
		int              steps;
		int              rand_base;
		bit              squeeze;
		logic [ID_W-1:0] pool [0:10];
		logic [CFG_W-1:0] cap_pick;
		logic [CFG_W-1:0] pcount_pick;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_CAPACITY;
		cfg_data = '0;
		in_valid = 1'b0;
		kind = KIND_CLEAR;
		part_id = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty plan, ignored kind, free-slot admits, end of sequence
		add_row(check_row(KIND_SIMULATE, 6'd0, OUT_END, 0, 0, 0));
		add_row(item_row(KIND_UNUSED, 6'h3F));
		add_row(item_row(KIND_APPEND, 6'd63));
		add_row(item_row(KIND_APPEND, 6'd0));
		add_row(check_row(KIND_SIMULATE, 6'd0, OUT_ADMIT, 63, 0, 0));
		add_row(check_row(KIND_SIMULATE, 6'h3F, OUT_ADMIT, 0, 0, 1));
		add_row(check_row(KIND_SIMULATE, 6'd0, OUT_END, 0, 0, 2));
		// evictions: farthest use, tie among never-used, pair partner kept
		add_row(item_row(KIND_APPEND, 6'd5));
		add_row(item_row(KIND_APPEND, 6'd63));
		add_row(item_row(KIND_APPEND, 6'd7));
		add_row(item_row(KIND_APPEND, 6'd0));
		repeat (4) add_row(item_row(KIND_SIMULATE, 6'd0));
		// full buffer with no eligible candidate
		add_row(reg_row(REG_PCOUNT, 7'd1));
		add_row(item_row(KIND_CLEAR, 6'h2A));
		add_row(item_row(KIND_APPEND, 6'd9));
		add_row(item_row(KIND_APPEND, 6'd12));
		add_row(item_row(KIND_APPEND, 6'd40));
		add_row(check_row(KIND_SIMULATE, 6'd0, OUT_ADMIT, 9, 0, 0));
		add_row(check_row(KIND_SIMULATE, 6'd0, OUT_ADMIT, 12, 0, 1));
		add_row(check_row(KIND_SIMULATE, 6'd0, OUT_ADMIT, 40, 0, 2));
		add_row(check_row(KIND_SIMULATE, 6'd0, OUT_END, 0, 0, 3));
		add_row(reg_row(REG_PCOUNT, 7'd64));

		foreach (dir_rows[r]) begin
			if (dir_rows[r].is_reg) begin
				drain_plans();
				write_reg(dir_rows[r].reg_sel, dir_rows[r].reg_val);
			end else begin
				send_req(dir_rows[r].kind, dir_rows[r].pid, dir_rows[r].typed, dir_rows[r].want);
			end
		end
		drain_plans();

		rand_base = useful_reqs;
		phase = 0;
		while (useful_reqs < rand_base + RAND_ITEMS) begin
			phase++;
			if (phase == 1 || $urandom_range(0, 3) == 0) begin
				case ($urandom_range(0, 9))
					0: cap_pick = 7'd0;
					1: cap_pick = 7'd1;
					2: cap_pick = 7'd64;
					3: cap_pick = CFG_W'($urandom_range(65, 126));
					4: cap_pick = 7'd127;
					default: cap_pick = CFG_W'($urandom_range(2, 6));
				endcase
				case ($urandom_range(0, 7))
					0: pcount_pick = 7'd0;
					1: pcount_pick = 7'd1;
					2: pcount_pick = CFG_W'($urandom_range(2, 63));
					3: pcount_pick = 7'd127;
					default: pcount_pick = 7'd64;
				endcase
				write_reg(REG_CAPACITY, cap_pick);
				write_reg(REG_PCOUNT, pcount_pick);
			end
			fast_mode = ($urandom_range(0, 4) == 0);
			squeeze = (phase == 3 || $urandom_range(0, 11) == 0);
			if (phase == 3 || $urandom_range(0, 6) != 0) begin
				// well-formed plan: load batches from a small pool, then replay it
				if (seq_len > 800 || $urandom_range(0, 4) != 0)
					send_req(KIND_CLEAR, ID_W'($urandom));
				plen = 2 * $urandom_range(1, 12) - ($urandom_range(0, 5) == 0 ? 1 : 0);
				pool_n = $urandom_range(2, (cap_val < 8 ? cap_val : 8) + 3);
				for (int i = 0; i < pool_n; i++)
					pool[i] = ID_W'($urandom_range(0, 63));
				for (int i = 0; i < plen; i++)
					send_req(KIND_APPEND, pool[$urandom_range(0, pool_n - 1)]);
				steps = seq_len - step_pos + $urandom_range(0, 2);
				// keep offering requests while the result side is held off
				if (squeeze)
					hold_req = HOLD_CYCLES;
				for (int s = 0; s < steps; s++) begin
					case ($urandom_range(0, 19))
						0: send_req(KIND_APPEND, pool[$urandom_range(0, pool_n - 1)]);
						1: send_req(KIND_UNUSED, ID_W'($urandom));
						default: ;
					endcase
					send_req(KIND_SIMULATE, ID_W'($urandom));
				end
			end else begin
				repeat ($urandom_range(5, 15))
					send_req(KIND_W'($urandom_range(0, 3)), ID_W'($urandom));
			end
			drain_plans();
		end

		// long sequence: scans over many accesses, then replay to the end
		write_reg(REG_CAPACITY, 7'd3);
		write_reg(REG_PCOUNT, 7'd64);
		fast_mode = 1'b0;
		send_req(KIND_CLEAR, '0);
		repeat (LONG_LEN) send_req(KIND_APPEND, ID_W'($urandom));
		repeat (LONG_SIMS) send_req(KIND_SIMULATE, ID_W'($urandom));
		drain_plans();
		write_reg(REG_CAPACITY, 7'd64);
		fast_mode = 1'b1;
		while (step_pos < seq_len)
			send_req(KIND_SIMULATE, ID_W'($urandom));
		fast_mode = 1'b0;
		send_req(KIND_SIMULATE, 6'h3F);
		drain_plans();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (swap_q.size() != 0)
			flag_mismatch($sformatf("%0d results never arrived", swap_q.size()));

		$display("Ran %0d requests over %0d plan phases with %0d register writes, %0d hold-offs.",
			useful_reqs, phase, reg_writes, holds_done);
		$display("Checked %0d results: %0d hits, %0d admits, %0d evictions, %0d past end; %0d bad.",
			results_seen, outcome_tally[OUT_HIT], outcome_tally[OUT_ADMIT],
			outcome_tally[OUT_EVICT], outcome_tally[OUT_END], mismatches);
		if (mismatches == 0)
			$display("[belady_partition_swap_planner] OK");
		else
			$display("[belady_partition_swap_planner] ERROR");
		$finish;
	end

endmodule
